// ===== src/sdr_pkg.sv =====
// Shared types for the signed divide and remainder pipeline.
`default_nettype none

package sdr_pkg;

    typedef struct packed {
        logic mode;
        logic rem_neg;
        logic quo_neg;
        logic div_zero;
    } sdr_ctrl_t;

    localparam logic MODE_QUOTIENT  = 1'b0;
    localparam logic MODE_REMAINDER = 1'b1;

endpackage

`default_nettype wire

// ===== src/signed_divide_remainder_top.sv =====
// Top level of the pipelined signed divide and remainder unit.
//
// The input channel (s_valid, s_ready) carries a mode bit, a signed dividend
// and a signed divisor. The result channel (m_valid, m_ready) returns the
// quotient truncated toward zero when the mode is zero, or the remainder with
// the dividend's sign when the mode is one, together with a divide-by-zero
// flag. A zero divisor gives a result of zero with the flag set.
// The pipeline has one operand stage, one stage per quotient bit and one
// sign and output stage, each a register that an accepted item passes through.
// One item is accepted every cycle while the receiver keeps up.
// When the receiver stalls a valid result, the whole pipeline holds and
// s_ready falls until that result is taken; no item is lost or repeated.
// Reset is synchronous and active low; it clears all valid bits, and the
// block accepts items in the first cycle after reset is released.
`default_nettype none

module signed_divide_remainder_top
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic signed [DATA_WIDTH-1:0] s_dividend,
    input  wire logic signed [DATA_WIDTH-1:0] s_divisor,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_result,
    output logic                              m_divide_by_zero
);

    logic                  advance;
    logic                  valid_w [0:DATA_WIDTH];
    sdr_ctrl_t             ctrl_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] nq_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] result_w;

    assign advance  = !m_valid || m_ready;
    assign s_ready  = advance;
    assign rem_w[0] = '0;

    sdr_prep #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_valid (s_valid),
        .mode     (s_mode),
        .dividend (s_dividend),
        .divisor  (s_divisor),
        .out_valid(valid_w[0]),
        .out_ctrl (ctrl_w[0]),
        .out_nq   (nq_w[0]),
        .out_den  (den_w[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        sdr_stage #(
            .DATA_WIDTH(DATA_WIDTH),
            .BIT       (DATA_WIDTH - 1 - k)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .in_valid (valid_w[k]),
            .in_ctrl  (ctrl_w[k]),
            .in_nq    (nq_w[k]),
            .in_den   (den_w[k]),
            .in_rem   (rem_w[k]),
            .out_valid(valid_w[k+1]),
            .out_ctrl (ctrl_w[k+1]),
            .out_nq   (nq_w[k+1]),
            .out_den  (den_w[k+1]),
            .out_rem  (rem_w[k+1])
        );
    end

    sdr_fix #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_fix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .in_valid    (valid_w[DATA_WIDTH]),
        .in_ctrl     (ctrl_w[DATA_WIDTH]),
        .in_quo      (nq_w[DATA_WIDTH]),
        .in_rem      (rem_w[DATA_WIDTH]),
        .out_valid   (m_valid),
        .out_result  (result_w),
        .out_div_zero(m_divide_by_zero)
    );

    assign m_result = result_w;

endmodule

`default_nettype wire

// ===== src/sdr_prep.sv =====
// Input stage that registers operand magnitudes and sign information.
`default_nettype none

module sdr_prep
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic                  mode,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       out_valid,
    output sdr_ctrl_t                  out_ctrl,
    output logic [DATA_WIDTH-1:0]      out_nq,
    output logic [DATA_WIDTH-1:0]      out_den
);

    logic                  valid_reg;
    sdr_ctrl_t             ctrl_reg;
    sdr_ctrl_t             ctrl_next;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] nq_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] den_next;
    logic                  a_neg;
    logic                  b_neg;

    always_comb begin
        a_neg              = dividend[DATA_WIDTH-1];
        b_neg              = divisor[DATA_WIDTH-1];
        nq_next            = a_neg ? (~dividend + 1'b1) : dividend;
        den_next           = b_neg ? (~divisor + 1'b1) : divisor;
        ctrl_next.mode     = mode;
        ctrl_next.rem_neg  = a_neg;
        ctrl_next.quo_neg  = a_neg ^ b_neg;
        ctrl_next.div_zero = (divisor == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            ctrl_reg <= ctrl_next;
            nq_reg   <= nq_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;

endmodule

`default_nettype wire

// ===== src/sdr_stage.sv =====
// One restoring division step that resolves a single quotient bit.
`default_nettype none

module sdr_stage
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int BIT        = 31
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire sdr_ctrl_t             in_ctrl,
    input  wire logic [DATA_WIDTH-1:0] in_nq,
    input  wire logic [DATA_WIDTH-1:0] in_den,
    input  wire logic [DATA_WIDTH-1:0] in_rem,
    output logic                       out_valid,
    output sdr_ctrl_t                  out_ctrl,
    output logic [DATA_WIDTH-1:0]      out_nq,
    output logic [DATA_WIDTH-1:0]      out_den,
    output logic [DATA_WIDTH-1:0]      out_rem
);

    logic                  valid_reg;
    sdr_ctrl_t             ctrl_reg;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] nq_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    // The partial remainder shifts in one dividend bit, and that bit's
    // position in the word then holds the resulting quotient bit.
    always_comb begin
        shifted  = {in_rem, in_nq[BIT]};
        diff     = shifted - {1'b0, in_den};
        nq_next  = in_nq;
        if (!diff[DATA_WIDTH]) begin
            rem_next     = diff[DATA_WIDTH-1:0];
            nq_next[BIT] = 1'b1;
        end else begin
            rem_next     = shifted[DATA_WIDTH-1:0];
            nq_next[BIT] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            ctrl_reg <= in_ctrl;
            nq_reg   <= nq_next;
            den_reg  <= in_den;
            rem_reg  <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;

endmodule

`default_nettype wire

// ===== src/sdr_fix.sv =====
// Output stage that restores signs, selects the result and holds it for the receiver.
`default_nettype none

module sdr_fix
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire sdr_ctrl_t             in_ctrl,
    input  wire logic [DATA_WIDTH-1:0] in_quo,
    input  wire logic [DATA_WIDTH-1:0] in_rem,
    output logic                       out_valid,
    output logic [DATA_WIDTH-1:0]      out_result,
    output logic                       out_div_zero
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic [DATA_WIDTH-1:0] result_next;
    logic                  div_zero_reg;
    logic [DATA_WIDTH-1:0] mag;
    logic                  neg;

    always_comb begin
        if (in_ctrl.mode == MODE_REMAINDER) begin
            mag = in_rem;
            neg = in_ctrl.rem_neg;
        end else begin
            mag = in_quo;
            neg = in_ctrl.quo_neg;
        end
        if (in_ctrl.div_zero) begin
            result_next = '0;
        end else if (neg) begin
            result_next = ~mag + 1'b1;
        end else begin
            result_next = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            result_reg   <= result_next;
            div_zero_reg <= in_ctrl.div_zero;
        end
    end

    assign out_valid    = valid_reg;
    assign out_result   = result_reg;
    assign out_div_zero = div_zero_reg;

endmodule

`default_nettype wire
